### src/uold_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uold_pkg
// shared types, constants and calendar helpers for the utc to local converter
// ----------------------------------------------------------------------------
package uold_pkg;

	localparam logic [7:0]  OFFSET_MAX    = 8'd104;
	localparam logic [7:0]  OFFSET_BIAS   = 8'd48;
	localparam logic [7:0]  OFFSET_RESET  = 8'd48;
	localparam logic [11:0] YEAR_MIN      = 12'd2000;
	localparam logic [11:0] YEAR_MAX      = 12'd2099;
	localparam logic [6:0]  MIN_PER_HOUR  = 7'd60;
	localparam logic [7:0]  HOURS_PER_DAY = 8'd24;
	localparam logic [4:0]  NOON          = 5'd12;
	localparam logic [3:0]  MONTH_JAN     = 4'd1;
	localparam logic [3:0]  MONTH_FEB     = 4'd2;
	localparam logic [3:0]  MONTH_DEC     = 4'd12;

	// register indexes on the apb port
	localparam logic REG_OFFSET = 1'b0;
	localparam logic REG_MODE   = 1'b1;

	typedef enum logic [1:0] {
		STEP_NONE,
		STEP_FWD,
		STEP_BACK
	} day_step_t;

	typedef struct packed {
		logic [7:0] offset;
		logic       twelve_hour;
	} cfg_t;

	typedef struct packed {
		logic [4:0] hour24;
		logic [5:0] minute;
		logic [4:0] disp_hour;
		logic       pm;
		day_step_t  step;
	} time_res_t;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic        valid;
	} date_res_t;

	// days in a month, zero for a month code that is no month
	function automatic logic [4:0] month_days(input logic leap_yr, input logic [3:0] m);
		logic [4:0] n;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
			MONTH_FEB:                                  n = leap_yr ? 5'd29 : 5'd28;
			default:                                    n = 5'd0;
		endcase
		return n;
	endfunction

endpackage

### src/uold_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uold_in_if / uold_out_if
// valid/ready channels for utc timestamps and local time results
// ----------------------------------------------------------------------------
interface uold_in_if;
	logic        valid;
	logic        ready;
	logic [11:0] utc_year;
	logic [3:0]  utc_month;
	logic [4:0]  utc_day;
	logic [4:0]  utc_hour;
	logic [5:0]  utc_minute;

	modport source (output valid, utc_year, utc_month, utc_day, utc_hour, utc_minute,
		input ready);
	modport sink (input valid, utc_year, utc_month, utc_day, utc_hour, utc_minute,
		output ready);
endinterface

interface uold_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  local_hour24;
	logic [5:0]  local_minute;
	logic [4:0]  display_hour;
	logic        is_pm;
	logic [11:0] local_year;
	logic [3:0]  local_month;
	logic [4:0]  local_day;
	logic        date_valid;

	modport source (output valid, local_hour24, local_minute, display_hour, is_pm,
		local_year, local_month, local_day, date_valid, input ready);
	modport sink (input valid, local_hour24, local_minute, display_hour, is_pm,
		local_year, local_month, local_day, date_valid, output ready);
endinterface

### src/uold_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uold_regs
// apb configuration registers: offset and twelve-hour mode
// ----------------------------------------------------------------------------
module uold_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output uold_pkg::cfg_t   cfg
);
	import uold_pkg::*;

	logic [7:0] offset_q;
	logic       mode_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RESET;
			mode_q   <= 1'b0;
		end else if (wr_en) begin
			case (paddr[2])
				REG_OFFSET: offset_q <= pwdata[7:0];
				REG_MODE:   mode_q   <= pwdata[0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_OFFSET: prdata = {24'd0, offset_q};
			REG_MODE:   prdata = {31'd0, mode_q};
			default:    prdata = 32'd0;
		endcase
	end

	assign cfg.offset      = offset_q;
	assign cfg.twelve_hour = mode_q;

endmodule

### src/uold_time_conv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uold_time_conv
// adds the quarter-hour offset, wraps the time of day, flags a day change
// ----------------------------------------------------------------------------
module uold_time_conv (
	input  logic [4:0]            utc_hour,
	input  logic [5:0]            utc_minute,
	input  uold_pkg::cfg_t        cfg,
	output uold_pkg::time_res_t   res
);
	import uold_pkg::*;

	logic [7:0]        off_sat;
	logic signed [7:0] off_q;
	logic signed [7:0] off_h;
	logic [5:0]        off_m;
	logic [6:0]        min_sum;
	logic              carry;
	logic signed [7:0] hour_sum;
	logic [7:0]        hour_wrap;
	logic [4:0]        h24;
	logic [4:0]        h12;

	always_comb begin
		off_sat = (cfg.offset > OFFSET_MAX) ? OFFSET_MAX : cfg.offset;
		off_q   = $signed(off_sat - OFFSET_BIAS);
		// floor split into whole hours and a quarter remainder
		off_h   = off_q >>> 2;
		case (off_q[1:0])
			2'd0:    off_m = 6'd0;
			2'd1:    off_m = 6'd15;
			2'd2:    off_m = 6'd30;
			default: off_m = 6'd45;
		endcase

		// minute sum stays below 120, so one carry at most
		min_sum = {1'b0, utc_minute} + {1'b0, off_m};
		carry   = (min_sum >= MIN_PER_HOUR);

		hour_sum = $signed({3'b000, utc_hour}) + off_h + $signed({7'd0, carry});

		// hour sum lies in -12..46, one wrap either way
		if (hour_sum < 0) begin
			hour_wrap = hour_sum + HOURS_PER_DAY;
			res.step  = STEP_BACK;
		end else if (hour_sum >= $signed(HOURS_PER_DAY)) begin
			hour_wrap = hour_sum - HOURS_PER_DAY;
			res.step  = STEP_FWD;
		end else begin
			hour_wrap = hour_sum;
			res.step  = STEP_NONE;
		end
		h24 = hour_wrap[4:0];

		res.hour24 = h24;
		res.minute = carry ? 6'(min_sum - MIN_PER_HOUR) : min_sum[5:0];
		res.pm     = (h24 >= NOON);
		h12        = (h24 >= NOON) ? (h24 - NOON) : h24;
		if (cfg.twelve_hour)
			res.disp_hour = (h12 == 5'd0) ? NOON : h12;
		else
			res.disp_hour = h24;
	end

endmodule

### src/uold_date_adj.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uold_date_adj
// moves the date one day either way and checks the calendar range
// ----------------------------------------------------------------------------
module uold_date_adj (
	input  logic [11:0]           utc_year,
	input  logic [3:0]            utc_month,
	input  logic [4:0]            utc_day,
	input  uold_pkg::day_step_t   step,
	output uold_pkg::date_res_t   res
);
	import uold_pkg::*;

	// leap rule reduces to divisible by four inside 2000..2099; outside
	// that range the date is invalid anyway
	logic        leap_in;
	logic [4:0]  md_in;
	logic        in_ok;
	logic [11:0] y_adj;
	logic [3:0]  m_adj;
	logic [4:0]  d_adj;
	logic [11:0] y_prev;
	logic        ok;

	always_comb begin
		leap_in = (utc_year[1:0] == 2'b00);
		md_in   = month_days(leap_in, utc_month);
		in_ok   = (utc_year >= YEAR_MIN) && (utc_year <= YEAR_MAX) &&
			(md_in != 5'd0) && (utc_day != 5'd0) && (utc_day <= md_in);
		y_prev  = utc_year - 12'd1;

		y_adj = utc_year;
		m_adj = utc_month;
		d_adj = utc_day;
		case (step)
			STEP_FWD: begin
				if (utc_day < md_in) begin
					d_adj = utc_day + 5'd1;
				end else begin
					d_adj = 5'd1;
					if (utc_month < MONTH_DEC) begin
						m_adj = utc_month + 4'd1;
					end else begin
						m_adj = MONTH_JAN;
						y_adj = utc_year + 12'd1;
					end
				end
			end
			STEP_BACK: begin
				if (utc_day > 5'd1) begin
					d_adj = utc_day - 5'd1;
				end else if (utc_month > MONTH_JAN) begin
					m_adj = utc_month - 4'd1;
					d_adj = month_days(leap_in, m_adj);
				end else begin
					m_adj = MONTH_DEC;
					y_adj = y_prev;
					d_adj = month_days(y_prev[1:0] == 2'b00, MONTH_DEC);
				end
			end
			default: ;
		endcase

		// a valid input date stays a real date after one step, only the year can leave range
		ok = in_ok && (y_adj >= YEAR_MIN) && (y_adj <= YEAR_MAX);

		res.valid = ok;
		res.year  = ok ? y_adj : 12'd0;
		res.month = ok ? m_adj : 4'd0;
		res.day   = ok ? d_adj : 5'd0;
	end

endmodule

### src/utc_offset_local_datetime.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_offset_local_datetime
// utc date and time to local date and time with a quarter-hour offset
// ----------------------------------------------------------------------------
// usage
//  - utc: valid/ready channel of utc timestamps (year, month, day, hour, minute)
//  - loc: valid/ready channel of results; one result per transfer on utc
//  - apb port: register 0 at byte 0 is the biased quarter-hour offset (48 is
//    utc, above 104 counts as 104), register 1 at byte 4 is twelve-hour mode;
//    write only while no transfer is in flight
//  - a timestamp is taken into an input register, converted by one short
//    combinational pass and caught in the output register
//  - path: the accepted timestamp waits in the input register, its result is
//    loaded into the output register, and only from there is it offered on loc
//  - throughput: one transfer per cycle while loc.ready is held high; utc.ready
//    stays high while the output register is free or drains
//  - receiver stall: the output register holds its result, the input register
//    still takes one more timestamp, then utc.ready drops
//  - reset: both pipeline stages empty, offset back to utc, 24-hour mode
// ----------------------------------------------------------------------------
module utc_offset_local_datetime (
	input  logic            clk,
	input  logic            arst_n,
	uold_in_if.sink         utc,
	uold_out_if.source      loc,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);
	import uold_pkg::*;

	cfg_t        cfg;
	time_res_t   tres;
	date_res_t   dres;

	// input stage
	logic        valid_s1;
	logic [11:0] year_s1;
	logic [3:0]  month_s1;
	logic [4:0]  day_s1;
	logic [4:0]  hour_s1;
	logic [5:0]  minute_s1;

	// result stage
	logic        valid_s2;
	time_res_t   time_s2;
	date_res_t   date_s2;

	logic        take_in;
	logic        load_s2;

	// result register loads when empty or being drained this cycle
	assign load_s2    = valid_s1 && (!valid_s2 || loc.ready);
	assign utc.ready  = !valid_s1 || load_s2;
	assign take_in    = utc.valid && utc.ready;

	uold_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	uold_time_conv u_time (
		.utc_hour   (hour_s1),
		.utc_minute (minute_s1),
		.cfg        (cfg),
		.res        (tres)
	);

	uold_date_adj u_date (
		.utc_year  (year_s1),
		.utc_month (month_s1),
		.utc_day   (day_s1),
		.step      (tres.step),
		.res       (dres)
	);

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_in)
				valid_s1 <= 1'b1;
			else if (load_s2)
				valid_s1 <= 1'b0;

			if (load_s2)
				valid_s2 <= 1'b1;
			else if (loc.ready)
				valid_s2 <= 1'b0;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (take_in) begin
			year_s1   <= utc.utc_year;
			month_s1  <= utc.utc_month;
			day_s1    <= utc.utc_day;
			hour_s1   <= utc.utc_hour;
			minute_s1 <= utc.utc_minute;
		end
		if (load_s2) begin
			time_s2 <= tres;
			date_s2 <= dres;
		end
	end

	assign loc.valid        = valid_s2;
	assign loc.local_hour24 = time_s2.hour24;
	assign loc.local_minute = time_s2.minute;
	assign loc.display_hour = time_s2.disp_hour;
	assign loc.is_pm        = time_s2.pm;
	assign loc.local_year   = date_s2.year;
	assign loc.local_month  = date_s2.month;
	assign loc.local_day    = date_s2.day;
	assign loc.date_valid   = date_s2.valid;

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// randomized check of the utc to local date and time converter
// ----------------------------------------------------------------------------
// utc timestamps go in on one valid/ready channel and local results come back
// on the other. a scoreboard keeps its own copy of the two apb registers,
// predicts every result from the accepted timestamp and compares it field by
// field. a directed corner set runs first, then phases of random timestamps
// under different offsets and hour modes, with random stalls on both sides,
// one long receiver hold-off and a drain before every register write
// ----------------------------------------------------------------------------
module testbench;
	import uold_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 135;
	localparam int SETTLE_CYCLES   = 6;
	localparam int LONG_HOLD       = 60;
	localparam int DRAIN_BOUND     = 5000;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
	} utc_stamp_t;

	typedef struct packed {
		logic [4:0]  hour24;
		logic [5:0]  minute;
		logic [4:0]  disp_hour;
		logic        pm;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic        valid;
	} local_stamp_t;

	// directed corners: calendar edges, leap days, bad dates and field extremes
	localparam utc_stamp_t CORNER_STAMPS [13] = '{
		'{12'd2000, 4'd1,  5'd1,  5'd0,  6'd0},   // first day of the range
		'{12'd2099, 4'd12, 5'd31, 5'd23, 6'd59},  // last minute of the range
		'{12'd2000, 4'd2,  5'd29, 5'd23, 6'd0},   // leap day of a century year
		'{12'd2000, 4'd3,  5'd1,  5'd1,  6'd0},   // back into a leap february
		'{12'd2001, 4'd3,  5'd1,  5'd5,  6'd0},   // back into a short february
		'{12'd2001, 4'd2,  5'd29, 5'd12, 6'd0},   // impossible leap day
		'{12'd2004, 4'd12, 5'd31, 5'd20, 6'd30},  // forward into a new year
		'{12'd2050, 4'd4,  5'd30, 5'd31, 6'd63},  // hour and minute past range
		'{12'd0,    4'd0,  5'd0,  5'd0,  6'd0},   // all fields zero
		'{12'd4095, 4'd15, 5'd31, 5'd31, 6'd63},  // all fields at their top
		'{12'd2010, 4'd13, 5'd1,  5'd10, 6'd0},   // month code past december
		'{12'd2010, 4'd6,  5'd0,  5'd10, 6'd0},   // day zero
		'{12'd2010, 4'd6,  5'd31, 5'd10, 6'd0}    // day past the month end
	};

	// ------------------------------------------------------------------------
	// scoreboard: register copy, local time prediction and result check
	// ------------------------------------------------------------------------
	class local_time_board;
		localparam int MINUTES_PER_DAY = 1440;

		int           month_len_tbl [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		local_stamp_t expected_q [$];
		logic [7:0]   offset_reg;
		logic         twelve_hour_reg;
		int           errors;
		int           stamps_seen;
		int           results_seen;

		function new();
			offset_reg      = OFFSET_RESET;
			twelve_hour_reg = 1'b0;
			errors          = 0;
			stamps_seen     = 0;
			results_seen    = 0;
		endfunction

		// only the low bits of the written word land in a register
		function void write_reg(logic idx, logic [31:0] data);
			if (idx == REG_OFFSET) begin
				offset_reg = data[7:0];
			end else if (idx == REG_MODE) begin
				twelve_hour_reg = data[0];
			end
		endfunction

		function int days_in_month(logic [11:0] y, logic [3:0] m);
			int   n;
			logic leap_yr;
			leap_yr = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
			if (m < MONTH_JAN || m > MONTH_DEC) begin
				n = 0;
			end else if (m == MONTH_FEB && leap_yr) begin
				n = 29;
			end else begin
				n = month_len_tbl[m - 1];
			end
			return n;
		endfunction

		function bit date_ok(logic [11:0] y, logic [3:0] m, logic [4:0] d);
			int md;
			md = days_in_month(y, m);
			return y >= YEAR_MIN && y <= YEAR_MAX && md > 0 && d >= 1 && d <= md;
		endfunction

		function local_stamp_t convert(utc_stamp_t s);
			local_stamp_t r;
			logic [7:0]   off;
			logic [11:0]  y;
			logic [3:0]   m;
			logic [4:0]   d;
			int           total;
			int           wrapped;
			int           h24;
			bit           in_ok;
			off = (offset_reg > OFFSET_MAX) ? OFFSET_MAX : offset_reg;
			total = int'(s.hour) * 60 + int'(s.minute) + (int'(off) - int'(OFFSET_BIAS)) * 15;
			wrapped = ((total % MINUTES_PER_DAY) + MINUTES_PER_DAY) % MINUTES_PER_DAY;
			h24 = wrapped / 60;
			r.hour24 = 5'(h24);
			r.minute = 6'(wrapped % 60);
			if (twelve_hour_reg) begin
				r.disp_hour = (h24 % 12 == 0) ? 5'd12 : 5'(h24 % 12);
			end else begin
				r.disp_hour = 5'(h24);
			end
			r.pm = (h24 >= 12);

			// the date moves by one day at most, forward for any count past midnight
			y = s.year;
			m = s.month;
			d = s.day;
			in_ok = date_ok(y, m, d);
			if (total >= MINUTES_PER_DAY) begin
				if (d < days_in_month(y, m)) begin
					d = d + 5'd1;
				end else begin
					d = 5'd1;
					if (m < MONTH_DEC) begin
						m = m + 4'd1;
					end else begin
						m = MONTH_JAN;
						y = y + 12'd1;
					end
				end
			end else if (total < 0) begin
				if (d > 1) begin
					d = d - 5'd1;
				end else begin
					if (m > MONTH_JAN) begin
						m = m - 4'd1;
					end else begin
						m = MONTH_DEC;
						y = y - 12'd1;
					end
					d = 5'(days_in_month(y, m));
				end
			end
			r.valid = in_ok && date_ok(y, m, d);
			r.year  = r.valid ? y : 12'd0;
			r.month = r.valid ? m : 4'd0;
			r.day   = r.valid ? d : 5'd0;
			return r;
		endfunction

		function void note_stamp(utc_stamp_t s);
			expected_q.push_back(convert(s));
			stamps_seen++;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void compare_field(string name, logic [11:0] want, logic [11:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(local_stamp_t got);
			local_stamp_t want;
			results_seen++;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result with no timestamp waiting: expected none, actual %h",
					$time, got);
				return;
			end
			want = expected_q.pop_front();
			compare_field("local_hour24", 12'(want.hour24),    12'(got.hour24));
			compare_field("local_minute", 12'(want.minute),    12'(got.minute));
			compare_field("display_hour", 12'(want.disp_hour), 12'(got.disp_hour));
			compare_field("is_pm",        12'(want.pm),        12'(got.pm));
			compare_field("local_year",   want.year,           got.year);
			compare_field("local_month",  12'(want.month),     12'(got.month));
			compare_field("local_day",    12'(want.day),       12'(got.day));
			compare_field("date_valid",   12'(want.valid),     12'(got.valid));
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// clock, reset and the block
	// ------------------------------------------------------------------------
	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	uold_in_if  utc_ch ();
	uold_out_if loc_ch ();

	local_time_board sb;

	bit idle_on;         // random idling on both sides
	int hold_cycles;     // long receiver hold-off, counted down by the sink
	int cycle_count;
	int settings_used;

	utc_offset_local_datetime u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.utc     (utc_ch),
		.loc     (loc_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit, far above the slowest legal run
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** utc_offset_local_datetime: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// monitors: every transfer on either channel is seen at the clock edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (utc_ch.valid && utc_ch.ready) begin
				sb.note_stamp('{utc_ch.utc_year, utc_ch.utc_month, utc_ch.utc_day,
					utc_ch.utc_hour, utc_ch.utc_minute});
			end
			if (loc_ch.valid && loc_ch.ready) begin
				sb.check_result('{loc_ch.local_hour24, loc_ch.local_minute,
					loc_ch.display_hour, loc_ch.is_pm, loc_ch.local_year,
					loc_ch.local_month, loc_ch.local_day, loc_ch.date_valid});
			end
		end
	end

	// ------------------------------------------------------------------------
	// receiver: random stall bursts, plus one long hold-off on request
	// ------------------------------------------------------------------------
	initial begin
		int stall_left;
		stall_left = 0;
		loc_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				loc_ch.ready <= 1'b0;
				hold_cycles--;
			end else if (stall_left > 0) begin
				loc_ch.ready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				loc_ch.ready <= 1'b0;
				stall_left = $urandom_range(1, 4) - 1;
			end else begin
				loc_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// sender and register tasks
	// ------------------------------------------------------------------------

	// offer one timestamp, maybe after an idle burst, and return at its transfer
	task automatic send_stamp(input utc_stamp_t s);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			utc_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		utc_ch.valid      <= 1'b1;
		utc_ch.utc_year   <= s.year;
		utc_ch.utc_month  <= s.month;
		utc_ch.utc_day    <= s.day;
		utc_ch.utc_hour   <= s.hour;
		utc_ch.utc_minute <= s.minute;
		do @(posedge clk); while (!utc_ch.ready);
	endtask

	// stop offering and wait until every predicted result has come back
	task automatic wait_results();
		int waited;
		waited = 0;
		utc_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0 && waited < DRAIN_BOUND) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// setup cycle, access cycle, register written at the edge with pready
	task automatic apb_write(input logic idx, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	// junk in the upper bits checks that only the register width is kept
	task automatic set_regs(input logic [7:0] offset, input logic twelve_hour);
		apb_write(REG_OFFSET, {24'($urandom), offset});
		apb_write(REG_MODE, {31'($urandom), twelve_hour});
		settings_used++;
	endtask

	// mostly real dates near day, month and year edges, the rest raw noise
	function automatic utc_stamp_t random_stamp();
		utc_stamp_t s;
		int         md;
		if ($urandom_range(0, 9) < 8) begin
			case ($urandom_range(0, 7))
				0:       s.year = YEAR_MIN;
				1:       s.year = YEAR_MAX;
				default: s.year = 12'($urandom_range(YEAR_MIN, YEAR_MAX));
			endcase
			s.month = 4'($urandom_range(MONTH_JAN, MONTH_DEC));
			md = sb.days_in_month(s.year, s.month);
			case ($urandom_range(0, 3))
				0:       s.day = 5'd1;
				1:       s.day = 5'(md);
				default: s.day = 5'($urandom_range(1, md));
			endcase
			case ($urandom_range(0, 3))
				0:       s.hour = 5'($urandom_range(0, 2));
				1:       s.hour = 5'($urandom_range(21, 23));
				default: s.hour = 5'($urandom_range(0, 23));
			endcase
			s.minute = 6'($urandom_range(0, 59));
		end else begin
			s = utc_stamp_t'($urandom);
		end
		return s;
	endfunction

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [7:0] phase_offset;
		logic       phase_mode;

		sb            = new();
		idle_on       = 1'b1;
		hold_cycles   = 0;
		settings_used = 0;

		arst_n            <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		utc_ch.valid      <= 1'b0;
		utc_ch.utc_year   <= '0;
		utc_ch.utc_month  <= '0;
		utc_ch.utc_day    <= '0;
		utc_ch.utc_hour   <= '0;
		utc_ch.utc_minute <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners at the two ends of the offset range, one per hour mode;
		// 255 also checks the saturation to +14:00
		set_regs(8'd0, 1'b1);
		foreach (CORNER_STAMPS[i]) send_stamp(CORNER_STAMPS[i]);
		wait_results();
		set_regs(8'd255, 1'b0);
		foreach (CORNER_STAMPS[i]) send_stamp(CORNER_STAMPS[i]);

		// random phases, each behind a full drain so the registers change idle
		for (int p = 0; p < PHASES; p++) begin
			wait_results();
			case (p)
				0:       phase_offset = 8'd0;
				1:       phase_offset = 8'd255;
				2:       phase_offset = OFFSET_MAX;
				3:       phase_offset = OFFSET_BIAS;
				4:       phase_offset = 8'($urandom_range(105, 254));
				default: phase_offset = 8'($urandom_range(0, 255));
			endcase
			phase_mode = (p < 4) ? p[0] : 1'($urandom);
			set_regs(phase_offset, phase_mode);

			// the final phase runs flat out with no idling at all
			idle_on = (p != PHASES - 1);

			// long receiver hold-off while transfers keep being offered
			if (p == 2) hold_cycles = LONG_HOLD;

			repeat (ITEMS_PER_PHASE) send_stamp(random_stamp());
		end

		wait_results();
		if (sb.pending() != 0) begin
			$display("%0t: %0d results never arrived", $time, sb.pending());
			sb.errors += sb.pending();
		end

		$display("run covered %0d timestamps and %0d results over %0d register settings",
			sb.stamps_seen, sb.results_seen, settings_used);
		$display("offsets -12:00 to +14:00 with saturation, both hour modes, rollovers, bad dates");
		if (sb.errors == 0) begin
			$display("** utc_offset_local_datetime: PASSED **");
		end else begin
			$display("** utc_offset_local_datetime: FAILED **");
		end
		$finish;
	end

endmodule

### utc_offset_local_datetime.f
src/uold_pkg.sv
src/uold_if.sv
src/uold_regs.sv
src/uold_time_conv.sv
src/uold_date_adj.sv
src/utc_offset_local_datetime.sv
test/testbench.sv
